// File: rtl/oadc_pkg.sv
// Shared types and constants for the obstacle-avoiding drive controller.
// Holds the command codes, direction and phase codes, register map and the
// classified request record passed between the front end and the back end.
package oadc_pkg;

	// Received command characters.
	localparam logic [7:0] CHR_AUTO  = 8'h41; // 'A'
	localparam logic [7:0] CHR_PAUSE = 8'h50; // 'P'
	localparam logic [7:0] CHR_FRONT = 8'h46; // 'F'
	localparam logic [7:0] CHR_BACK  = 8'h42; // 'B'
	localparam logic [7:0] CHR_LEFT  = 8'h4C; // 'L'
	localparam logic [7:0] CHR_RIGHT = 8'h52; // 'R'
	localparam logic [7:0] CHR_STOP  = 8'h53; // 'S'

	// Register reset values.
	localparam logic [7:0]  RST_CENTER_STOP = 8'd30;
	localparam logic [7:0]  RST_SIDE_NEAR   = 8'd20;
	localparam logic [15:0] RST_STOP_WAIT   = 16'd100;
	localparam logic [15:0] RST_AVOID_TURN  = 16'd300;
	localparam logic [6:0]  RST_CRUISE      = 7'd30;
	localparam logic [6:0]  RST_TURN        = 7'd50;
	localparam logic [6:0]  RST_MANUAL      = 7'd100;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_STOP = 3'd0,
		REG_SIDE_NEAR   = 3'd1,
		REG_STOP_WAIT   = 3'd2,
		REG_AVOID_TURN  = 3'd3,
		REG_CRUISE      = 3'd4,
		REG_TURN        = 3'd5,
		REG_MANUAL      = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		DIR_FRONT = 3'd0,
		DIR_BACK  = 3'd1,
		DIR_LEFT  = 3'd2,
		DIR_RIGHT = 3'd3,
		DIR_STOP  = 3'd4
	} dir_t;

	typedef enum logic [1:0] {
		PH_SCAN  = 2'd0,
		PH_STOP  = 2'd1,
		PH_AVOID = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		CMD_AUTO,
		CMD_PAUSE,
		CMD_FRONT,
		CMD_BACK,
		CMD_LEFT,
		CMD_RIGHT,
		CMD_STOP,
		CMD_OTHER
	} cmd_kind_t;

	typedef struct packed {
		logic [7:0]  center_stop_cm;
		logic [7:0]  side_near_cm;
		logic [15:0] stop_wait_ms;
		logic [15:0] avoid_turn_ms;
		logic [6:0]  cruise_speed;
		logic [6:0]  turn_speed;
		logic [6:0]  manual_speed;
	} cfg_t;

	// One classified request as queued between front end and back end.
	typedef struct packed {
		logic       is_tick;
		logic [7:0] cmd_byte;
		cmd_kind_t  kind;
		logic       center_near;
		logic       left_near;
		logic       right_near;
		logic       left_wider;
	} item_t;

endpackage

// File: rtl/oadc_if.sv
// Request and result channel interfaces of the drive controller.
// Plain valid/ready channels; no package dependency.
interface oadc_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] cmd_byte;
	logic [7:0] dist_left;
	logic [7:0] dist_center;
	logic [7:0] dist_right;

	modport source (output valid, req_type, cmd_byte, dist_left, dist_center, dist_right,
		input ready);
	modport sink (input valid, req_type, cmd_byte, dist_left, dist_center, dist_right,
		output ready);
endinterface

interface oadc_rsp_if;
	logic       valid;
	logic       ready;
	logic       echo_valid;
	logic [7:0] echo_byte;
	logic       drive_valid;
	logic [2:0] drive_dir;
	logic [6:0] drive_speed;
	logic       auto_active;
	logic [1:0] phase;

	modport source (output valid, echo_valid, echo_byte, drive_valid, drive_dir,
		drive_speed, auto_active, phase, input ready);
	modport sink (input valid, echo_valid, echo_byte, drive_valid, drive_dir,
		drive_speed, auto_active, phase, output ready);
endinterface

// File: rtl/obstacle_avoid_drive_controller_core.sv
// An accepted request goes into the queue, then from its head into the result
// register. Throughput: one request per cycle sustained while results are taken;
// the back end retires one queued request per cycle into a free result register,
// and the queue depth sets how many are absorbed while the result side stalls.
// Reset: registers return to defaults, manual mode, stop phase, timer zero,
// queue empty and no result pending.
module obstacle_avoid_drive_controller_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	oadc_req_if.sink                         req,
	oadc_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [oadc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [oadc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	oadc_pkg::cfg_t  cfg_q;
	logic            push;
	logic            pop;
	logic            full;
	logic            head_valid;
	oadc_pkg::item_t push_item;
	oadc_pkg::item_t head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_stop_cm <= oadc_pkg::RST_CENTER_STOP;
			cfg_q.side_near_cm   <= oadc_pkg::RST_SIDE_NEAR;
			cfg_q.stop_wait_ms   <= oadc_pkg::RST_STOP_WAIT;
			cfg_q.avoid_turn_ms  <= oadc_pkg::RST_AVOID_TURN;
			cfg_q.cruise_speed   <= oadc_pkg::RST_CRUISE;
			cfg_q.turn_speed     <= oadc_pkg::RST_TURN;
			cfg_q.manual_speed   <= oadc_pkg::RST_MANUAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				oadc_pkg::REG_CENTER_STOP: cfg_q.center_stop_cm <= cfg_wdata[7:0];
				oadc_pkg::REG_SIDE_NEAR:   cfg_q.side_near_cm   <= cfg_wdata[7:0];
				oadc_pkg::REG_STOP_WAIT:   cfg_q.stop_wait_ms   <= cfg_wdata;
				oadc_pkg::REG_AVOID_TURN:  cfg_q.avoid_turn_ms  <= cfg_wdata;
				oadc_pkg::REG_CRUISE:      cfg_q.cruise_speed   <= cfg_wdata[6:0];
				oadc_pkg::REG_TURN:        cfg_q.turn_speed     <= cfg_wdata[6:0];
				oadc_pkg::REG_MANUAL:      cfg_q.manual_speed   <= cfg_wdata[6:0];
				default: begin
				end
			endcase
		end
	end

	// Front end classifies requests into the queue.
	oadc_front u_front (
		.req  (req),
		.cfg  (cfg_q),
		.full (full),
		.push (push),
		.item (push_item)
	);

	// Queue between front end and back end.
	oadc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back end runs the mode and phase logic and drives the result channel.
	oadc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

// File: rtl/oadc_front.sv
// Front end: accepts requests and classifies them into queue records.
// Depends on oadc_pkg and the request interface in oadc_if.
module oadc_front (
	oadc_req_if.sink      req,
	input  oadc_pkg::cfg_t cfg,
	input  logic           full,
	output logic           push,
	output oadc_pkg::item_t item
);

	oadc_pkg::cmd_kind_t kind;

	// A request is taken whenever the queue has room.
	assign req.ready = !full;
	assign push      = req.valid && !full;

	// Decode the command character.
	always_comb begin
		unique case (req.cmd_byte)
			oadc_pkg::CHR_AUTO:  kind = oadc_pkg::CMD_AUTO;
			oadc_pkg::CHR_PAUSE: kind = oadc_pkg::CMD_PAUSE;
			oadc_pkg::CHR_FRONT: kind = oadc_pkg::CMD_FRONT;
			oadc_pkg::CHR_BACK:  kind = oadc_pkg::CMD_BACK;
			oadc_pkg::CHR_LEFT:  kind = oadc_pkg::CMD_LEFT;
			oadc_pkg::CHR_RIGHT: kind = oadc_pkg::CMD_RIGHT;
			oadc_pkg::CHR_STOP:  kind = oadc_pkg::CMD_STOP;
			default:             kind = oadc_pkg::CMD_OTHER;
		endcase
	end

	// Distance checks. A zero reading never counts as near.
	always_comb begin
		item.is_tick     = req.req_type;
		item.cmd_byte    = req.cmd_byte;
		item.kind        = kind;
		item.center_near = (req.dist_center != 8'd0) && (req.dist_center < cfg.center_stop_cm);
		item.left_near   = (req.dist_left != 8'd0) && (req.dist_left < cfg.side_near_cm);
		item.right_near  = (req.dist_right != 8'd0) && (req.dist_right < cfg.side_near_cm);
		item.left_wider  = req.dist_left > req.dist_right;
	end

endmodule

// File: rtl/oadc_fifo.sv
// Short request queue between the front end and the back end.
// Depends on oadc_pkg for the queued record type.
module oadc_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  oadc_pkg::item_t push_item,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output oadc_pkg::item_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	oadc_pkg::item_t entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: rtl/oadc_back.sv
// Back end: carries out queued requests on the mode and phase state and
// holds the result register. Depends on oadc_pkg and oadc_rsp_if.
module oadc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  oadc_pkg::cfg_t  cfg,
	input  logic            head_valid,
	input  oadc_pkg::item_t head,
	output logic            pop,
	oadc_rsp_if.source      rsp
);

	logic                auto_mode_q;
	oadc_pkg::phase_t    phase_q;
	logic [15:0]         elapsed_q;
	logic                rsp_valid_q;
	logic                echo_valid_q;
	logic [7:0]          echo_byte_q;
	logic                drive_valid_q;
	oadc_pkg::dir_t      drive_dir_q;
	logic [6:0]          drive_speed_q;

	logic                nxt_mode;
	oadc_pkg::phase_t    nxt_phase;
	logic [15:0]         nxt_elapsed;
	logic [15:0]         bumped;
	logic                nxt_echo_valid;
	logic [7:0]          nxt_echo_byte;
	logic                nxt_drive_valid;
	oadc_pkg::dir_t      nxt_dir;
	logic [6:0]          nxt_speed;

	// The result register frees up when it is empty or being taken.
	assign pop = head_valid && (!rsp_valid_q || rsp.ready);

	// Saturating phase timer increment.
	assign bumped = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

	// Next state and result for the request at the queue head.
	always_comb begin
		nxt_mode        = auto_mode_q;
		nxt_phase       = phase_q;
		nxt_elapsed     = elapsed_q;
		nxt_echo_valid  = 1'b0;
		nxt_echo_byte   = 8'd0;
		nxt_drive_valid = 1'b0;
		nxt_dir         = oadc_pkg::DIR_FRONT;
		nxt_speed       = 7'd0;
		if (!head.is_tick) begin
			nxt_echo_valid = 1'b1;
			nxt_echo_byte  = head.cmd_byte;
			if (head.kind == oadc_pkg::CMD_AUTO) begin
				nxt_mode  = 1'b1;
				nxt_phase = oadc_pkg::PH_SCAN;
			end
			if (head.kind == oadc_pkg::CMD_PAUSE) begin
				nxt_mode        = 1'b0;
				nxt_phase       = oadc_pkg::PH_SCAN;
				nxt_drive_valid = 1'b1;
				nxt_dir         = oadc_pkg::DIR_STOP;
			end
			// Manual drive commands act only outside auto mode.
			if (!nxt_mode) begin
				case (head.kind)
					oadc_pkg::CMD_FRONT: begin
						nxt_drive_valid = 1'b1;
						nxt_dir         = oadc_pkg::DIR_FRONT;
						nxt_speed       = cfg.manual_speed;
					end
					oadc_pkg::CMD_BACK: begin
						nxt_drive_valid = 1'b1;
						nxt_dir         = oadc_pkg::DIR_BACK;
						nxt_speed       = cfg.manual_speed;
					end
					oadc_pkg::CMD_LEFT: begin
						nxt_drive_valid = 1'b1;
						nxt_dir         = oadc_pkg::DIR_LEFT;
						nxt_speed       = cfg.manual_speed;
					end
					oadc_pkg::CMD_RIGHT: begin
						nxt_drive_valid = 1'b1;
						nxt_dir         = oadc_pkg::DIR_RIGHT;
						nxt_speed       = cfg.manual_speed;
					end
					oadc_pkg::CMD_STOP: begin
						nxt_drive_valid = 1'b1;
						nxt_dir         = oadc_pkg::DIR_STOP;
					end
					default: begin
					end
				endcase
			end
		end else if (auto_mode_q) begin
			unique case (phase_q)
				oadc_pkg::PH_SCAN: begin
					nxt_drive_valid = 1'b1;
					if (head.center_near) begin
						nxt_dir     = oadc_pkg::DIR_STOP;
						nxt_elapsed = 16'd0;
						nxt_phase   = oadc_pkg::PH_STOP;
					end else if (head.left_near) begin
						nxt_dir   = oadc_pkg::DIR_RIGHT;
						nxt_speed = cfg.cruise_speed;
					end else if (head.right_near) begin
						nxt_dir   = oadc_pkg::DIR_LEFT;
						nxt_speed = cfg.cruise_speed;
					end else begin
						nxt_dir   = oadc_pkg::DIR_FRONT;
						nxt_speed = cfg.cruise_speed;
					end
				end
				oadc_pkg::PH_STOP: begin
					nxt_elapsed = bumped;
					if (bumped >= cfg.stop_wait_ms) begin
						nxt_drive_valid = 1'b1;
						nxt_dir         = head.left_wider ? oadc_pkg::DIR_LEFT
							: oadc_pkg::DIR_RIGHT;
						nxt_speed       = cfg.turn_speed;
						nxt_elapsed     = 16'd0;
						nxt_phase       = oadc_pkg::PH_AVOID;
					end
				end
				oadc_pkg::PH_AVOID: begin
					nxt_elapsed = bumped;
					if (bumped >= cfg.avoid_turn_ms) begin
						nxt_phase = oadc_pkg::PH_SCAN;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Control state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q <= 1'b0;
			phase_q     <= oadc_pkg::PH_STOP;
			elapsed_q   <= 16'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				auto_mode_q <= nxt_mode;
				phase_q     <= nxt_phase;
				elapsed_q   <= nxt_elapsed;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			echo_valid_q  <= nxt_echo_valid;
			echo_byte_q   <= nxt_echo_byte;
			drive_valid_q <= nxt_drive_valid;
			drive_dir_q   <= nxt_dir;
			drive_speed_q <= nxt_speed;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.echo_valid  = echo_valid_q;
	assign rsp.echo_byte   = echo_byte_q;
	assign rsp.drive_valid = drive_valid_q;
	assign rsp.drive_dir   = drive_dir_q;
	assign rsp.drive_speed = drive_speed_q;
	assign rsp.auto_active = auto_mode_q;
	assign rsp.phase       = phase_q;

	// A tick in manual mode leaves mode, phase and timer alone.
	a_manual_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.is_tick && !auto_mode_q)
		|=> ($stable(auto_mode_q) && $stable(phase_q) && $stable(elapsed_q)))
		else $error("manual tick changed auto state");

	// Every taken request produces a result; echo only for commands.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (rsp.valid && (rsp.echo_valid == !$past(head.is_tick))))
		else $error("result register not loaded as expected");

	// Leaving the stop phase for avoid always issues a turn.
	a_avoid_turns: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && auto_mode_q && head.is_tick && phase_q == oadc_pkg::PH_STOP
			&& nxt_phase == oadc_pkg::PH_AVOID)
		|-> (nxt_drive_valid && nxt_speed == cfg.turn_speed
			&& (nxt_dir == oadc_pkg::DIR_LEFT || nxt_dir == oadc_pkg::DIR_RIGHT)))
		else $error("avoid entered without a turn command");

endmodule

// File: tb/sv/obstacle_avoid_drive_controller_core_test.sv
// Self-checking testbench for the obstacle-avoiding drive controller core.
// Uses oadc_pkg and the oadc_req_if / oadc_rsp_if channels; predicts every result
// from its own copy of the controller state and compares it field by field.
module obstacle_avoid_drive_controller_core_test;

	typedef struct {
		logic       is_tick;
		logic [7:0] cmd;
		logic [7:0] dl;
		logic [7:0] dc;
		logic [7:0] dr;
	} vehicle_req_t;

	typedef struct {
		logic       echo_valid;
		logic [7:0] echo_byte;
		logic       drive_valid;
		logic [2:0] drive_dir;
		logic [6:0] drive_speed;
		logic       auto_active;
		logic [1:0] phase;
	} vehicle_rsp_t;

	localparam logic [7:0] MANUAL_CHARS [5] = '{oadc_pkg::CHR_FRONT, oadc_pkg::CHR_BACK,
		oadc_pkg::CHR_LEFT, oadc_pkg::CHR_RIGHT, oadc_pkg::CHR_STOP};
	localparam int PHASE_COUNT = 9;
	localparam int PHASE_ITEMS = 230;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [oadc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [oadc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	oadc_req_if req_ch ();
	oadc_rsp_if rsp_ch ();

	obstacle_avoid_drive_controller_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Predicted controller state and register copies.
	logic              mdl_auto;
	oadc_pkg::phase_t  mdl_phase;
	logic [15:0]       mdl_elapsed;
	logic [7:0]        mdl_center;
	logic [7:0]        mdl_side;
	logic [15:0]       mdl_stop_wait;
	logic [15:0]       mdl_avoid_turn;
	logic [6:0]        mdl_cruise;
	logic [6:0]        mdl_turn;
	logic [6:0]        mdl_manual;

	vehicle_req_t req_backlog[$];
	vehicle_rsp_t rsp_expected[$];
	vehicle_req_t on_bus;
	vehicle_rsp_t drv_prediction;
	vehicle_rsp_t seen;
	vehicle_rsp_t want;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	logic stall_hold = 1'b0;
	int mismatch_count = 0;
	int cmd_count = 0;
	int tick_count = 0;
	int drive_count = 0;
	int checked_count = 0;

	always #5 clk = ~clk;

	// Step the predicted controller by one accepted request.
	task automatic predict_drive(input vehicle_req_t it, output vehicle_rsp_t r);
		r = '{default: '0};
		if (!it.is_tick) begin
			r.echo_valid = 1'b1;
			r.echo_byte = it.cmd;
			if (it.cmd == oadc_pkg::CHR_AUTO) begin
				mdl_auto = 1'b1;
				mdl_phase = oadc_pkg::PH_SCAN;
			end
			if (it.cmd == oadc_pkg::CHR_PAUSE) begin
				r.drive_valid = 1'b1;
				r.drive_dir = oadc_pkg::DIR_STOP;
				r.drive_speed = '0;
				mdl_auto = 1'b0;
				mdl_phase = oadc_pkg::PH_SCAN;
			end
			if (!mdl_auto) begin
				case (it.cmd)
					oadc_pkg::CHR_FRONT: begin
						r.drive_valid = 1'b1;
						r.drive_dir = oadc_pkg::DIR_FRONT;
						r.drive_speed = mdl_manual;
					end
					oadc_pkg::CHR_BACK: begin
						r.drive_valid = 1'b1;
						r.drive_dir = oadc_pkg::DIR_BACK;
						r.drive_speed = mdl_manual;
					end
					oadc_pkg::CHR_LEFT: begin
						r.drive_valid = 1'b1;
						r.drive_dir = oadc_pkg::DIR_LEFT;
						r.drive_speed = mdl_manual;
					end
					oadc_pkg::CHR_RIGHT: begin
						r.drive_valid = 1'b1;
						r.drive_dir = oadc_pkg::DIR_RIGHT;
						r.drive_speed = mdl_manual;
					end
					oadc_pkg::CHR_STOP: begin
						r.drive_valid = 1'b1;
						r.drive_dir = oadc_pkg::DIR_STOP;
						r.drive_speed = '0;
					end
					default: ;
				endcase
			end
		end else if (mdl_auto) begin
			case (mdl_phase)
				oadc_pkg::PH_SCAN: begin
					r.drive_valid = 1'b1;
					if (it.dc != 0 && it.dc < mdl_center) begin
						r.drive_dir = oadc_pkg::DIR_STOP;
						r.drive_speed = '0;
						mdl_elapsed = '0;
						mdl_phase = oadc_pkg::PH_STOP;
					end else if (it.dl != 0 && it.dl < mdl_side) begin
						r.drive_dir = oadc_pkg::DIR_RIGHT;
						r.drive_speed = mdl_cruise;
					end else if (it.dr != 0 && it.dr < mdl_side) begin
						r.drive_dir = oadc_pkg::DIR_LEFT;
						r.drive_speed = mdl_cruise;
					end else begin
						r.drive_dir = oadc_pkg::DIR_FRONT;
						r.drive_speed = mdl_cruise;
					end
				end
				oadc_pkg::PH_STOP: begin
					if (mdl_elapsed != 16'hFFFF)
						mdl_elapsed = mdl_elapsed + 16'd1;
					// Pause over: turn toward the side with the larger raw reading; a tie turns right.
					if (mdl_elapsed >= mdl_stop_wait) begin
						r.drive_valid = 1'b1;
						r.drive_dir = (it.dl > it.dr) ? oadc_pkg::DIR_LEFT
							: oadc_pkg::DIR_RIGHT;
						r.drive_speed = mdl_turn;
						mdl_elapsed = '0;
						mdl_phase = oadc_pkg::PH_AVOID;
					end
				end
				oadc_pkg::PH_AVOID: begin
					if (mdl_elapsed != 16'hFFFF)
						mdl_elapsed = mdl_elapsed + 16'd1;
					if (mdl_elapsed >= mdl_avoid_turn)
						mdl_phase = oadc_pkg::PH_SCAN;
				end
				default: ;
			endcase
		end
		r.auto_active = mdl_auto;
		r.phase = mdl_phase;
	endtask

	function automatic void check_field(string name, int unsigned exp_val,
		int unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
				act_val);
			mismatch_count++;
		end
	endfunction

	// Driver: predicts each accepted request and offers the next pending one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predict_drive(on_bus, drv_prediction);
				rsp_expected.push_back(drv_prediction);
				if (on_bus.is_tick)
					tick_count++;
				else
					cmd_count++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					on_bus = req_backlog.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= on_bus.is_tick;
					req_ch.cmd_byte <= on_bus.cmd;
					req_ch.dist_left <= on_bus.dl;
					req_ch.dist_center <= on_bus.dc;
					req_ch.dist_right <= on_bus.dr;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.echo_valid = rsp_ch.echo_valid;
				seen.echo_byte = rsp_ch.echo_byte;
				seen.drive_valid = rsp_ch.drive_valid;
				seen.drive_dir = rsp_ch.drive_dir;
				seen.drive_speed = rsp_ch.drive_speed;
				seen.auto_active = rsp_ch.auto_active;
				seen.phase = rsp_ch.phase;
				if (rsp_expected.size() == 0) begin
					$display("%0t: expected no result, actual echo %0d drive %0d",
						$time, seen.echo_byte, seen.drive_dir);
					mismatch_count++;
				end else begin
					want = rsp_expected.pop_front();
					check_field("echo_valid", want.echo_valid, seen.echo_valid);
					check_field("echo_byte", want.echo_byte, seen.echo_byte);
					check_field("drive_valid", want.drive_valid, seen.drive_valid);
					check_field("drive_dir", want.drive_dir, seen.drive_dir);
					check_field("drive_speed", want.drive_speed, seen.drive_speed);
					check_field("auto_active", want.auto_active, seen.auto_active);
					check_field("phase", want.phase, seen.phase);
					checked_count++;
					if (want.drive_valid)
						drive_count++;
				end
			end
			rsp_ch.ready <= !stall_hold && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off so the core backs up and stalls its request side.
	initial begin
		wait (hold_req);
		@(posedge clk);
		stall_hold <= 1'b1;
		repeat (300) @(posedge clk);
		stall_hold <= 1'b0;
	end

	// Distances around a threshold, with no-reading and full-range values.
	function automatic logic [7:0] pick_dist(logic [7:0] thr);
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 8'd0;
			1, 2, 3: return (thr > 1) ? 8'($urandom_range(1, int'(thr) - 1)) :
				8'($urandom_range(0, 255));
			4: return thr;
			5: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic vehicle_req_t make_tick();
		vehicle_req_t it;
		it.is_tick = 1'b1;
		it.cmd = 8'($urandom);
		it.dl = pick_dist(mdl_side);
		it.dc = pick_dist(mdl_center);
		it.dr = pick_dist(mdl_side);
		if ($urandom_range(0, 15) == 0)
			it.dr = it.dl;
		return it;
	endfunction

	function automatic vehicle_req_t make_cmd(logic [7:0] c);
		vehicle_req_t it;
		it.is_tick = 1'b0;
		it.cmd = c;
		it.dl = 8'($urandom);
		it.dc = 8'($urandom);
		it.dr = 8'($urandom);
		return it;
	endfunction

	function automatic vehicle_req_t make_fixed_tick(logic [7:0] l, logic [7:0] c,
		logic [7:0] r);
		vehicle_req_t it;
		it.is_tick = 1'b1;
		it.cmd = 8'($urandom);
		it.dl = l;
		it.dc = c;
		it.dr = r;
		return it;
	endfunction

	function automatic logic [6:0] pick_speed();
		case ($urandom_range(0, 5))
			0: return 7'd0;
			1: return 7'd100;
			2: return 7'd127;
			default: return 7'($urandom_range(0, 100));
		endcase
	endfunction

	function automatic logic [15:0] pick_wait();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 12));
	endfunction

	// One register write; the predicted copy follows the same masking.
	task automatic write_reg(oadc_pkg::cfg_idx_t idx, logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			oadc_pkg::REG_CENTER_STOP: mdl_center = data[7:0];
			oadc_pkg::REG_SIDE_NEAR: mdl_side = data[7:0];
			oadc_pkg::REG_STOP_WAIT: mdl_stop_wait = data;
			oadc_pkg::REG_AVOID_TURN: mdl_avoid_turn = data;
			oadc_pkg::REG_CRUISE: mdl_cruise = data[6:0];
			oadc_pkg::REG_TURN: mdl_turn = data[6:0];
			oadc_pkg::REG_MANUAL: mdl_manual = data[6:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(logic [7:0] center, logic [7:0] side, logic [15:0] stop_w,
		logic [15:0] avoid_t, logic [6:0] cruise, logic [6:0] turn, logic [6:0] manual);
		write_reg(oadc_pkg::REG_CENTER_STOP, {8'($urandom), center});
		write_reg(oadc_pkg::REG_SIDE_NEAR, {8'($urandom), side});
		write_reg(oadc_pkg::REG_STOP_WAIT, stop_w);
		write_reg(oadc_pkg::REG_AVOID_TURN, avoid_t);
		write_reg(oadc_pkg::REG_CRUISE, {9'($urandom), cruise});
		write_reg(oadc_pkg::REG_TURN, {9'($urandom), turn});
		write_reg(oadc_pkg::REG_MANUAL, {9'($urandom), manual});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every request is sent and every result has come back.
	task automatic wait_idle();
		int guard;
		@(negedge clk);
		while (req_backlog.size() != 0 || req_ch.valid)
			@(negedge clk);
		guard = 0;
		while (rsp_expected.size() != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		if (rsp_expected.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, rsp_expected.size());
			mismatch_count++;
			rsp_expected.delete();
		end
		repeat (4) @(negedge clk);
	endtask

	// Mostly auto-mode tick runs with random content, plus stray commands.
	task automatic fill_random_phase(int count);
		int sel;
		req_backlog.push_back(make_cmd(oadc_pkg::CHR_AUTO));
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 84)
				req_backlog.push_back(make_tick());
			else if (sel < 92)
				req_backlog.push_back(make_cmd(MANUAL_CHARS[$urandom_range(0, 4)]));
			else if (sel < 95)
				req_backlog.push_back(make_cmd(oadc_pkg::CHR_AUTO));
			else if (sel < 97) begin
				req_backlog.push_back(make_cmd(oadc_pkg::CHR_PAUSE));
				if ($urandom_range(0, 1))
					req_backlog.push_back(make_cmd(oadc_pkg::CHR_AUTO));
			end else
				req_backlog.push_back(make_cmd(8'($urandom)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = 1'b0;
		req_ch.cmd_byte = '0;
		req_ch.dist_left = '0;
		req_ch.dist_center = '0;
		req_ch.dist_right = '0;
		rsp_ch.ready = 1'b0;
		mdl_auto = 1'b0;
		mdl_phase = oadc_pkg::PH_STOP;
		mdl_elapsed = '0;
		mdl_center = oadc_pkg::RST_CENTER_STOP;
		mdl_side = oadc_pkg::RST_SIDE_NEAR;
		mdl_stop_wait = oadc_pkg::RST_STOP_WAIT;
		mdl_avoid_turn = oadc_pkg::RST_AVOID_TURN;
		mdl_cruise = oadc_pkg::RST_CRUISE;
		mdl_turn = oadc_pkg::RST_TURN;
		mdl_manual = oadc_pkg::RST_MANUAL;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: manual commands, unknown bytes, scan decisions at reset values.
		@(negedge clk);
		req_backlog.push_back(make_fixed_tick(8'd5, 8'd5, 8'd5));
		foreach (MANUAL_CHARS[i])
			req_backlog.push_back(make_cmd(MANUAL_CHARS[i]));
		req_backlog.push_back(make_cmd(8'h00));
		req_backlog.push_back(make_cmd(8'hFF));
		req_backlog.push_back(make_cmd(oadc_pkg::CHR_PAUSE));
		req_backlog.push_back(make_cmd(oadc_pkg::CHR_AUTO));
		req_backlog.push_back(make_cmd(oadc_pkg::CHR_FRONT));
		req_backlog.push_back(make_fixed_tick(8'd255, 8'd255, 8'd255));
		req_backlog.push_back(make_fixed_tick(8'd19, 8'd30, 8'd19));
		req_backlog.push_back(make_fixed_tick(8'd20, 8'd30, 8'd1));
		req_backlog.push_back(make_fixed_tick(8'd0, 8'd0, 8'd0));
		req_backlog.push_back(make_fixed_tick(8'd0, 8'd29, 8'd0));
		req_backlog.push_back(make_cmd(oadc_pkg::CHR_AUTO));
		wait_idle();

		// Directed: zero waits so stop and avoid each end on their first tick.
		apply_config(8'd30, 8'd20, 16'd0, 16'd0, 7'd127, 7'd0, 7'd100);
		@(negedge clk);
		req_backlog.push_back(make_cmd(oadc_pkg::CHR_AUTO));
		req_backlog.push_back(make_fixed_tick(8'd90, 8'd1, 8'd40));
		req_backlog.push_back(make_fixed_tick(8'd90, 8'd1, 8'd40));
		req_backlog.push_back(make_fixed_tick(8'd9, 8'd9, 8'd9));
		req_backlog.push_back(make_fixed_tick(8'd9, 8'd9, 8'd9));
		req_backlog.push_back(make_fixed_tick(8'd0, 8'd9, 8'd50));
		req_backlog.push_back(make_fixed_tick(8'd50, 8'd50, 8'd50));
		req_backlog.push_back(make_cmd(oadc_pkg::CHR_PAUSE));
		wait_idle();

		// Random phases over several settings and idling patterns.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: apply_config(oadc_pkg::RST_CENTER_STOP, oadc_pkg::RST_SIDE_NEAR,
					oadc_pkg::RST_STOP_WAIT, oadc_pkg::RST_AVOID_TURN,
					oadc_pkg::RST_CRUISE, oadc_pkg::RST_TURN, oadc_pkg::RST_MANUAL);
				1: apply_config(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 7'd127, 7'd127, 7'd127);
				2: apply_config(8'd0, 8'd0, 16'd0, 16'd0, 7'd0, 7'd0, 7'd0);
				default: apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					pick_wait(), pick_wait(), pick_speed(), pick_speed(), pick_speed());
			endcase
			@(negedge clk);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 70;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 70;
				end
				default: begin
					send_idle_pct = 18;
					recv_stall_pct = 18;
				end
			endcase
			if (ph == 4)
				hold_req = 1'b1;
			fill_random_phase(PHASE_ITEMS);
			wait_idle();
		end

		$display("Covered %0d command and %0d tick requests over %0d register settings.",
			cmd_count, tick_count, PHASE_COUNT + 2);
		$display("Checked %0d results, %0d of them with a drive command.", checked_count,
			drive_count);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
